[rtl/tlph_pkg.sv]
// Shared types and constants for the tagged linear-probe hash table.
// No dependencies; imported by every module in rtl/.
package tlph_pkg;

  localparam int LOG2_SLOTS = 12;
  localparam int DEPTH      = 1 << LOG2_SLOTS;
  localparam int SLOT_W     = LOG2_SLOTS;
  localparam int MIN_LOG2   = 5;

  localparam logic [31:0] CRC_POLY  = 32'h82F63B78;
  localparam logic [31:0] HASH_MULT = 32'h8648DBDB;
  localparam logic [31:0] GOLDEN    = 32'h9E3779B9;
  localparam logic [31:0] SEED_RST  = 32'hAAAAAAAA;
  localparam logic [7:0]  TAG_EMPTY = 8'hFF;
  localparam logic [3:0]  CAP_RST   = 4'd12;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_PROBE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_BLOOM    = 2'd1;
  localparam logic [1:0] REG_SEED     = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;
  localparam logic [2:0] ST_BLOOM    = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  typedef struct packed {
    logic       load;
    logic       crc_step;
    logic [2:0] byte_sel;
    logic       mul;
    logic       set_pos;
    logic       rd;
    logic       adv;
    logic       wr_ins;
    logic       clr_wr;
    logic       fin;
    logic       hit;
    logic       slot_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic tag_empty;
    logic tag_eq;
    logic key_eq;
    logic bloom_fail;
    logic wrap;
    logic clr_last;
  } dp_stat_t;

endpackage

[rtl/tlph_datapath.sv]
// Datapath: config registers, CRC32C/multiply hash, slot and Bloom memories, walk pointer.
// Depends on tlph_pkg; driven by tlph_ctrl through dp_cmd_t.
module tlph_datapath import tlph_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [63:0] key,
  input  logic [63:0] value,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [63:0] found_value,
  output logic [11:0] slot_index
);

  logic [3:0]  capacity_log2;
  logic        bloom_enable;
  logic [31:0] hash_seed;

  logic [63:0] key_r;
  logic [63:0] val_r;
  logic [31:0] crc;
  logic [31:0] hash_hi;
  logic [31:0] gold;
  logic [SLOT_W-1:0] pos;
  logic [SLOT_W-1:0] clr_cnt;

  logic [7:0]  tag_mem   [DEPTH];
  logic [63:0] key_mem   [DEPTH];
  logic [63:0] val_mem   [DEPTH];
  logic [15:0] bloom_mem [DEPTH];

  logic [7:0]  tag_q;
  logic [63:0] key_q;
  logic [63:0] val_q;
  logic [15:0] bloom_q;

  logic [3:0]  cap_eff;
  logic [SLOT_W-1:0] slot_mask;
  logic [SLOT_W-1:0] home;
  logic [SLOT_W-1:0] pos_inc;
  logic [7:0]  tag;
  logic [15:0] bloom_bits;
  logic [31:0] crc_next;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  always_comb begin
    if (capacity_log2 < 4'(MIN_LOG2)) begin
      cap_eff = 4'(MIN_LOG2);
    end else if (capacity_log2 > 4'(LOG2_SLOTS)) begin
      cap_eff = 4'(LOG2_SLOTS);
    end else begin
      cap_eff = capacity_log2;
    end
  end

  assign slot_mask  = SLOT_W'((32'd1 << cap_eff) - 32'd1);
  assign home       = crc[SLOT_W-1:0] & slot_mask;
  assign pos_inc    = (pos + SLOT_W'(1)) & slot_mask;
  assign tag        = (hash_hi[31:24] == TAG_EMPTY) ? 8'd0 : hash_hi[31:24];
  assign bloom_bits = (16'd1 << gold[3:0]) | (16'd1 << gold[11:8]) |
                      (16'd1 << gold[19:16]) | (16'd1 << gold[27:24]);
  assign crc_next   = crc_byte(crc, key_r[{cmd.byte_sel, 3'b000} +: 8]);

  assign stat.tag_empty  = (tag_q == TAG_EMPTY);
  assign stat.tag_eq     = (tag_q == tag);
  assign stat.key_eq     = (key_q == key_r);
  assign stat.bloom_fail = bloom_enable && ((bloom_q & bloom_bits) != bloom_bits);
  assign stat.wrap       = (pos_inc == home);
  assign stat.clr_last   = (clr_cnt == SLOT_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_log2 <= CAP_RST;
      bloom_enable  <= 1'b0;
      hash_seed     <= SEED_RST;
      clr_cnt       <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CAPACITY: capacity_log2 <= cfg_data[3:0];
          REG_BLOOM:    bloom_enable  <= cfg_data[0];
          REG_SEED:     hash_seed     <= cfg_data;
          default:      ;
        endcase
      end
      if (cmd.load) begin
        clr_cnt <= '0;
      end else if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= key;
      val_r <= value;
      crc   <= hash_seed;
    end
    if (cmd.crc_step) begin
      crc <= crc_next;
    end
    if (cmd.mul) begin
      hash_hi <= crc * HASH_MULT;
      gold    <= {21'd0, crc[31:21]} * GOLDEN;
    end
    if (cmd.set_pos) begin
      pos <= home;
    end else if (cmd.adv) begin
      pos <= pos_inc;
    end
    if (cmd.fin) begin
      found_value <= cmd.hit ? val_q : 64'd0;
      slot_index  <= cmd.slot_ok ? 12'(pos) : 12'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      tag_mem[clr_cnt] <= TAG_EMPTY;
    end else if (cmd.wr_ins) begin
      tag_mem[pos] <= tag;
    end
    if (cmd.rd) begin
      tag_q <= tag_mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_ins) begin
      key_mem[pos] <= key_r;
    end
    if (cmd.rd) begin
      key_q <= key_mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_ins) begin
      val_mem[pos] <= val_r;
    end
    if (cmd.rd) begin
      val_q <= val_mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      bloom_mem[clr_cnt] <= 16'd0;
    end else if (cmd.wr_ins && bloom_enable) begin
      bloom_mem[home] <= bloom_q | bloom_bits;
    end
    if (cmd.rd) begin
      bloom_q <= bloom_mem[home];
    end
  end

endmodule

[rtl/tlph_ctrl.sv]
// Controller: sequences clear sweep, CRC bytes, hash multiply and the probe walk.
// Depends on tlph_pkg; drives tlph_datapath through dp_cmd_t.
module tlph_ctrl import tlph_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] command,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done,
  output logic [2:0] status
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_CRC, S_MUL, S_SETPOS, S_RD, S_CHK
  } state_t;

  state_t     state, state_next;
  logic [1:0] op;
  logic [2:0] byte_cnt;
  logic       report;
  logic [2:0] res_code;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    res_code   = ST_MISS;
    cmd.byte_sel = byte_cnt;
    case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
          cmd.fin    = report;
          res_code   = ST_CLEARED;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (command == CMD_CLEAR) begin
            state_next = S_CLR;
          end else if (command == CMD_INSERT || command == CMD_PROBE) begin
            state_next = S_CRC;
          end else begin
            cmd.fin  = 1'b1;
            res_code = ST_MISS;
          end
        end
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (byte_cnt == 3'd7) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SETPOS;
      end
      S_SETPOS: begin
        cmd.set_pos = 1'b1;
        state_next  = S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        state_next = S_IDLE;
        cmd.fin    = 1'b1;
        if (op == CMD_PROBE && stat.bloom_fail) begin
          res_code = ST_BLOOM;
        end else if (stat.tag_empty) begin
          if (op == CMD_INSERT) begin
            cmd.wr_ins  = 1'b1;
            cmd.slot_ok = 1'b1;
            res_code    = ST_INSERTED;
          end else begin
            res_code = ST_MISS;
          end
        end else if (op == CMD_INSERT && stat.key_eq) begin
          cmd.slot_ok = 1'b1;
          res_code    = ST_DUP;
        end else if (op == CMD_PROBE && stat.tag_eq && stat.key_eq) begin
          cmd.slot_ok = 1'b1;
          cmd.hit     = 1'b1;
          res_code    = ST_HIT;
        end else if (stat.wrap) begin
          res_code = (op == CMD_INSERT) ? ST_FULL : ST_MISS;
        end else begin
          cmd.fin    = 1'b0;
          cmd.adv    = 1'b1;
          state_next = S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      report   <= 1'b0;
      byte_cnt <= 3'd0;
      done     <= 1'b0;
      status   <= ST_MISS;
      op       <= CMD_INSERT;
    end else begin
      state <= state_next;
      done  <= cmd.fin;
      if (cmd.fin) begin
        status <= res_code;
      end
      if (cmd.load) begin
        op       <= command;
        report   <= 1'b1;
        byte_cnt <= 3'd0;
      end else if (cmd.crc_step) begin
        byte_cnt <= byte_cnt + 3'd1;
      end
    end
  end

endmodule

[rtl/tagged_linear_probe_hash_table.sv]
// Top level: insert/probe/clear engine for a 4096-slot tagged linear-probe table.
// Insert/probe steps: CRC over the 8 key bytes, multiply, home slot, then a read and a check per slot walked.
// Clear: the tag and Bloom memories are swept one slot per cycle, over all 4096 slots.
// One item at a time; busy is high after accept until the result strobe (not for the unused command). No output stall.
// After reset the same clearing sweep runs with busy high and no result.
module tagged_linear_probe_hash_table import tlph_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [63:0] key,
  input  logic [63:0] value,
  output logic        done,
  output logic [2:0]  status,
  output logic [63:0] found_value,
  output logic [11:0] slot_index
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tlph_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  tlph_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .key        (key),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .found_value(found_value),
    .slot_index (slot_index)
  );

endmodule

[rtl/tlph_checker.sv]
// Port-level checker for the hash table top level, attached by bind.
// Depends on tlph_pkg and tagged_linear_probe_hash_table.
module tlph_checker import tlph_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  command,
  input logic        done,
  input logic [2:0]  status,
  input logic [63:0] found_value,
  input logic [11:0] slot_index
);

  a_reset_sweep: assert property (@(posedge clk) rst |=> busy)
    else $error("no clearing sweep after reset");

  a_unused_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == 2'd3) |=> (done && status == ST_MISS))
    else $error("unused command not answered with miss");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command != 2'd3) |=> busy)
    else $error("busy not raised after accept");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_HIT) |-> found_value == 64'd0)
    else $error("found_value nonzero without hit");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_MISS || status == ST_BLOOM || status == ST_FULL ||
              status == ST_CLEARED)) |-> slot_index == 12'd0)
    else $error("slot_index nonzero without a slot");

endmodule

bind tagged_linear_probe_hash_table tlph_checker u_tlph_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .command    (command),
  .done       (done),
  .status     (status),
  .found_value(found_value),
  .slot_index (slot_index)
);
